FILE: design/amt_pkg.sv
// Shared types and constants for the box transform block.
`timescale 1ns / 1ps
`default_nettype none
package amt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_COEFS   = 12;
  localparam int IDX_WIDTH   = 4;
  localparam int NUM_AXES    = 3;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage
`default_nettype wire

FILE: design/amt_if.sv
// Channel interfaces for the box transform block.
`timescale 1ns / 1ps
`default_nettype none
interface amt_in_if #(
  parameter int W = amt_pkg::COORD_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [amt_pkg::IDX_WIDTH-1:0]  coef_index;
  logic signed [W-1:0]            coef_value;
  logic signed [W-1:0]            box_min_x;
  logic signed [W-1:0]            box_min_y;
  logic signed [W-1:0]            box_min_z;
  logic signed [W-1:0]            box_max_x;
  logic signed [W-1:0]            box_max_y;
  logic signed [W-1:0]            box_max_z;

  modport source (
    output valid, cmd, coef_index, coef_value,
    output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, coef_index, coef_value,
    input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface amt_out_if #(
  parameter int W = amt_pkg::COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_min_x;
  logic signed [W-1:0] out_min_y;
  logic signed [W-1:0] out_min_z;
  logic signed [W-1:0] out_max_x;
  logic signed [W-1:0] out_max_y;
  logic signed [W-1:0] out_max_z;

  modport source (
    output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    input  ready
  );
  modport sink (
    input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    output ready
  );
endinterface
`default_nettype wire

FILE: design/amt_axis.sv
// Four-stage datapath for one output axis: products, per-term min and max, sum, shift and clamp.
`timescale 1ns / 1ps
`default_nettype none
module amt_axis #(
  parameter int COORD_WIDTH = amt_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = amt_pkg::FRAC_BITS
) (
  input  wire                                   clk,
  input  wire amt_pkg::stage_en_t               en,
  input  wire [3:0][COORD_WIDTH-1:0]            row,
  input  wire [2:0][COORD_WIDTH-1:0]            lo,
  input  wire [2:0][COORD_WIDTH-1:0]            hi,
  output logic signed [COORD_WIDTH-1:0]         mn,
  output logic signed [COORD_WIDTH-1:0]         mx
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = W + ((W > FRAC_BITS) ? W : FRAC_BITS) + 2;
  localparam logic signed [PW-1:0] SMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = ~SMAX;

  logic signed [2*W-1:0] plo_r [3];
  logic signed [2*W-1:0] phi_r [3];
  logic signed [W-1:0]   t1_r;
  logic signed [2*W-1:0] selmn_r [3];
  logic signed [2*W-1:0] selmx_r [3];
  logic signed [PW-1:0]  t2_r;
  logic signed [PW-1:0]  summn_r;
  logic signed [PW-1:0]  summx_r;
  logic signed [PW-1:0]  shmn;
  logic signed [PW-1:0]  shmx;

  // The transformed coordinate is separable per input axis, so the extreme corner
  // is the sum of the per-axis extreme terms; floor shift and clamp are monotonic.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < 3; c++) begin
        plo_r[c] <= $signed(row[c]) * $signed(lo[c]);
        phi_r[c] <= $signed(row[c]) * $signed(hi[c]);
      end
      t1_r <= $signed(row[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int c = 0; c < 3; c++) begin
        selmn_r[c] <= (plo_r[c] < phi_r[c]) ? plo_r[c] : phi_r[c];
        selmx_r[c] <= (plo_r[c] < phi_r[c]) ? phi_r[c] : plo_r[c];
      end
      t2_r <= PW'(t1_r) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      summn_r <= t2_r + PW'(selmn_r[0]) + PW'(selmn_r[1]) + PW'(selmn_r[2]);
      summx_r <= t2_r + PW'(selmx_r[0]) + PW'(selmx_r[1]) + PW'(selmx_r[2]);
    end
  end

  assign shmn = summn_r >>> FRAC_BITS;
  assign shmx = summx_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      if (shmn > SMAX) begin
        mn <= SMAX[W-1:0];
      end else if (shmn < SMIN) begin
        mn <= SMIN[W-1:0];
      end else begin
        mn <= shmn[W-1:0];
      end
      if (shmx > SMAX) begin
        mx <= SMAX[W-1:0];
      end else if (shmx < SMIN) begin
        mx <= SMIN[W-1:0];
      end else begin
        mx <= shmx[W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/aabb_matrix_transform.sv
// Top level of the axis-aligned box transform by a stored affine matrix.
`timescale 1ns / 1ps
`default_nettype none
// A load transaction writes one of twelve signed fixed-point coefficients (three rows
// of four, row-major; slots above eleven are ignored); reset loads the identity. A
// transform transaction carries a box and returns the box that bounds its eight
// transformed corners, each coordinate floor-shifted and clamped to the coordinate
// range. Transforms run through a four-stage pipeline (multiply, select, add, clamp),
// so a new transaction is taken every cycle unless output back-pressure fills the
// pipeline; a load takes effect for the very next transform.
module aabb_matrix_transform #(
  parameter int COORD_WIDTH = amt_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = amt_pkg::FRAC_BITS
) (
  input  wire    clk,
  input  wire    rst_n,
  amt_in_if.sink   in_ch,
  amt_out_if.source out_ch
);

  localparam int W = COORD_WIDTH;
  localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [W-1:0] ZERO = '0;
  localparam logic [amt_pkg::NUM_COEFS-1:0][W-1:0] COEF_IDENTITY =
    {ZERO, ONE, ZERO, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ZERO, ONE};

  logic [amt_pkg::NUM_COEFS-1:0][W-1:0] coef_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;
  logic is_load;
  amt_pkg::stage_en_t en;
  logic [2:0][W-1:0] lo;
  logic [2:0][W-1:0] hi;
  logic signed [W-1:0] mn [amt_pkg::NUM_AXES];
  logic signed [W-1:0] mx [amt_pkg::NUM_AXES];

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ch.ready = rdy1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign is_load = (in_ch.cmd == amt_pkg::CMD_LOAD);

  assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_IDENTITY;
    end else if (in_acc && is_load &&
                 (in_ch.coef_index < amt_pkg::IDX_WIDTH'(amt_pkg::NUM_COEFS))) begin
      coef_r[in_ch.coef_index] <= in_ch.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid && (in_ch.cmd == amt_pkg::CMD_XFORM);
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign lo = {in_ch.box_min_z, in_ch.box_min_y, in_ch.box_min_x};
  assign hi = {in_ch.box_max_z, in_ch.box_max_y, in_ch.box_max_x};

  for (genvar a = 0; a < amt_pkg::NUM_AXES; a++) begin : g_axis
    amt_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_axis (
      .clk (clk),
      .en  (en),
      .row ({coef_r[4*a+3], coef_r[4*a+2], coef_r[4*a+1], coef_r[4*a]}),
      .lo  (lo),
      .hi  (hi),
      .mn  (mn[a]),
      .mx  (mx[a])
    );
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.out_min_x = mn[0];
  assign out_ch.out_min_y = mn[1];
  assign out_ch.out_min_z = mn[2];
  assign out_ch.out_max_x = mx[0];
  assign out_ch.out_max_y = mx[1];
  assign out_ch.out_max_z = mx[2];

  a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_load) |=> !v1_r)
    else $error("A load transaction started a transform.");

  a_bad_slot_ignored : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_load &&
     (in_ch.coef_index >= amt_pkg::IDX_WIDTH'(amt_pkg::NUM_COEFS))) |=> $stable(coef_r))
    else $error("A load to an unused slot changed the matrix.");

  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("Input stalled while the pipeline had a free stage.");

  a_reset_identity : assert property (@(posedge clk)
    $past(!rst_n) |-> (coef_r[0] == ONE && coef_r[5] == ONE && coef_r[10] == ONE &&
                       coef_r[1] == '0 && coef_r[3] == '0))
    else $error("Matrix is not the identity after reset.");

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the box transform block with directed and random stimulus.
`timescale 1ns / 1ps
module testbench;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_ITEMS    = 900;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int ROW_STRIDE      = amt_pkg::NUM_COEFS / amt_pkg::NUM_AXES;
  localparam int COEF_SPAN       = 18;
  localparam int COORD_SPAN      = 24;

  typedef logic signed [amt_pkg::COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t [amt_pkg::NUM_AXES-1:0] lo;
    coord_t [amt_pkg::NUM_AXES-1:0] hi;
  } box_t;

  typedef struct packed {
    amt_pkg::cmd_t                 cmd;
    logic [amt_pkg::IDX_WIDTH-1:0] coef_index;
    coord_t                        coef_value;
    box_t                          box;
  } amt_item_t;

  typedef struct packed {
    amt_item_t item;
    logic      has_want;
    box_t      want;
  } directed_row_t;

  localparam coord_t Q_ONE = coord_t'(1 << amt_pkg::FRAC_BITS);
  localparam coord_t Q_MIN = {1'b1, {(amt_pkg::COORD_WIDTH-1){1'b0}}};
  localparam coord_t Q_MAX = {1'b0, {(amt_pkg::COORD_WIDTH-1){1'b1}}};
  localparam logic signed [127:0] SAT_HI = 128'(Q_MAX);
  localparam logic signed [127:0] SAT_LO = 128'(Q_MIN);

  logic          clk = 1'b0;
  logic          rst_n;
  int            error_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_cycles = 0;
  bit            hold_off_req = 1'b0;
  coord_t        coef_shadow [amt_pkg::NUM_COEFS];
  box_t          box_expect_q [$];
  directed_row_t directed_q [$];

  amt_in_if  in_ch ();
  amt_out_if out_ch ();

  aabb_matrix_transform i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  function automatic coord_t affine_row(int r, coord_t [amt_pkg::NUM_AXES-1:0] p);
    logic signed [127:0] acc;
    logic signed [127:0] coef;
    logic signed [127:0] coord;
    int c;
    acc = 128'(coef_shadow[r*ROW_STRIDE + amt_pkg::NUM_AXES]);
    acc = acc <<< amt_pkg::FRAC_BITS;
    for (c = 0; c < amt_pkg::NUM_AXES; c++) begin
      coef  = 128'(coef_shadow[r*ROW_STRIDE + c]);
      coord = 128'($signed(p[c]));
      acc   = acc + coef * coord;
    end
    acc = acc >>> amt_pkg::FRAC_BITS;
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    return acc[amt_pkg::COORD_WIDTH-1:0];
  endfunction

  function automatic box_t transform_box(box_t b);
    box_t                           r;
    coord_t [amt_pkg::NUM_AXES-1:0] corner;
    coord_t                         v;
    int                             k;
    int                             ax;
    r = '0;
    for (k = 0; k < 8; k++) begin
      corner[0] = k[2] ? b.hi[0] : b.lo[0];
      corner[1] = k[1] ? b.hi[1] : b.lo[1];
      corner[2] = k[0] ? b.hi[2] : b.lo[2];
      for (ax = 0; ax < amt_pkg::NUM_AXES; ax++) begin
        v = affine_row(ax, corner);
        if (k == 0 || $signed(v) < $signed(r.lo[ax])) begin
          r.lo[ax] = v;
        end
        if (k == 0 || $signed(v) > $signed(r.hi[ax])) begin
          r.hi[ax] = v;
        end
      end
    end
    return r;
  endfunction

  function automatic box_t make_box(input coord_t lx, ly, lz, hx, hy, hz);
    box_t b;
    b.lo = {lz, ly, lx};
    b.hi = {hz, hy, hx};
    return b;
  endfunction

  function automatic void add_load(logic [amt_pkg::IDX_WIDTH-1:0] idx, coord_t val);
    directed_row_t r;
    r = '0;
    r.item.cmd        = amt_pkg::CMD_LOAD;
    r.item.coef_index = idx;
    r.item.coef_value = val;
    directed_q.push_back(r);
  endfunction

  function automatic void add_xform(box_t b, logic has_want, box_t want);
    directed_row_t r;
    r = '0;
    r.item.cmd = amt_pkg::CMD_XFORM;
    r.item.box = b;
    r.has_want = has_want;
    r.want     = want;
    directed_q.push_back(r);
  endfunction

  function automatic coord_t rand_value(int unsigned span, int unsigned wild);
    if ($urandom_range(0, 15) >= wild) begin
      return coord_t'($urandom_range(0, 32'd2 << span)) - (coord_t'(1) <<< span);
    end
    case ($urandom_range(0, 3))
      0:       return Q_MIN;
      1:       return Q_MAX;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic amt_item_t random_item(amt_pkg::cmd_t cmd,
                                            logic [amt_pkg::IDX_WIDTH-1:0] idx);
    amt_item_t it;
    coord_t    a;
    coord_t    b;
    int        ax;
    it.cmd        = cmd;
    it.coef_index = idx;
    it.coef_value = rand_value(COEF_SPAN, 3);
    for (ax = 0; ax < amt_pkg::NUM_AXES; ax++) begin
      a = rand_value(COORD_SPAN, 4);
      b = rand_value(COORD_SPAN, 4);
      if ($urandom_range(0, 3) != 0 && a > b) begin
        it.box.lo[ax] = b;
        it.box.hi[ax] = a;
      end else begin
        it.box.lo[ax] = a;
        it.box.hi[ax] = b;
      end
    end
    return it;
  endfunction

  task automatic send_item(amt_item_t it, logic has_want, box_t want);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= it.cmd;
    in_ch.coef_index <= it.coef_index;
    in_ch.coef_value <= it.coef_value;
    in_ch.box_min_x  <= it.box.lo[0];
    in_ch.box_min_y  <= it.box.lo[1];
    in_ch.box_min_z  <= it.box.lo[2];
    in_ch.box_max_x  <= it.box.hi[0];
    in_ch.box_max_y  <= it.box.hi[1];
    in_ch.box_max_z  <= it.box.hi[2];
    do @(posedge clk); while (!in_ch.ready);
    if (it.cmd == amt_pkg::CMD_LOAD) begin
      if (it.coef_index < amt_pkg::NUM_COEFS) begin
        coef_shadow[it.coef_index] = it.coef_value;
      end
    end else begin
      box_expect_q.push_back(has_want ? want : transform_box(it.box));
    end
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (box_expect_q.size() != 0);
  endtask

  initial begin : stimulus
    box_t        id_box;
    box_t        ext_box;
    box_t        frac_box;
    int unsigned sent;
    int unsigned n;
    int unsigned k;
    bit          held;
    bit          drained;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= amt_pkg::CMD_LOAD;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    in_ch.box_min_x  <= '0;
    in_ch.box_min_y  <= '0;
    in_ch.box_min_z  <= '0;
    in_ch.box_max_x  <= '0;
    in_ch.box_max_y  <= '0;
    in_ch.box_max_z  <= '0;
    foreach (coef_shadow[i]) coef_shadow[i] = '0;
    coef_shadow[0]              = Q_ONE;
    coef_shadow[ROW_STRIDE + 1] = Q_ONE;
    coef_shadow[2*ROW_STRIDE + 2] = Q_ONE;

    id_box   = make_box(32'sh00010000, 32'sh00020000, 32'sh00030000,
                        32'sh00040000, 32'sh00050000, 32'sh00060000);
    ext_box  = make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    frac_box = make_box(32'shFFFE8000, 32'shFFFFC000, 32'shFFFD0000,
                        32'sh0002C000, 32'sh00008000, 32'sh00010000);

    // The identity matrix from reset passes ordered boxes through unchanged.
    add_xform(id_box, 1'b1, id_box);
    add_xform(ext_box, 1'b1, ext_box);
    add_xform(make_box(32'sh00050000, 32'shFFFF0000, 32'sh0, 32'shFFFB0000, 32'sh00010000, 32'sh0),
              1'b1,
              make_box(32'shFFFB0000, 32'shFFFF0000, 32'sh0, 32'sh00050000, 32'sh00010000, 32'sh0));
    add_load(4'd12, Q_MAX);
    add_load(4'd15, Q_MIN);
    add_xform(frac_box, 1'b1, frac_box);
    add_load(4'd0, Q_MIN);
    add_load(4'd1, Q_MAX);
    add_load(4'd2, 32'shFFFFFFFF);
    add_load(4'd3, Q_MAX);
    add_load(4'd4, 32'sh00000001);
    add_load(4'd5, Q_MIN);
    add_load(4'd6, Q_MAX);
    add_load(4'd7, Q_MIN);
    add_load(4'd8, 32'sh0);
    add_load(4'd9, Q_ONE);
    add_load(4'd10, Q_MAX);
    add_load(4'd11, -Q_ONE);
    add_xform(ext_box, 1'b0, '0);
    add_xform(frac_box, 1'b0, '0);
    add_xform(id_box, 1'b0, '0);
    add_xform(make_box(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0), 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) begin
      send_item(directed_q[i].item, directed_q[i].has_want, directed_q[i].want);
      pace_sender();
    end
    drain_results();

    sent    = 0;
    held    = 1'b0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (!held && sent >= RANDOM_ITEMS / 3) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      if (!drained && sent >= 2 * RANDOM_ITEMS / 3) begin
        drain_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        for (k = 0; k < amt_pkg::NUM_COEFS; k++) begin
          send_item(random_item(amt_pkg::CMD_LOAD, amt_pkg::IDX_WIDTH'(k)), 1'b0, '0);
          pace_sender();
        end
        sent += amt_pkg::NUM_COEFS;
      end else begin
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
          send_item(random_item(amt_pkg::CMD_LOAD,
                                amt_pkg::IDX_WIDTH'($urandom_range(0, 15))), 1'b0, '0);
          pace_sender();
        end
        sent += n;
      end
      n = $urandom_range(2, 8);
      for (k = 0; k < n; k++) begin
        send_item(random_item(amt_pkg::CMD_XFORM,
                              amt_pkg::IDX_WIDTH'($urandom_range(0, 15))), 1'b0, '0);
        pace_sender();
      end
      sent += n;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && box_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned phase_left;
    int unsigned tick;
    int unsigned held_cycles;
    mode       = 0;
    phase_left = 0;
    tick       = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        for (held_cycles = 0; held_cycles < HOLD_OFF_CYCLES; held_cycles++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(8, 80);
      end
      phase_left--;
      tick++;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
        2:       out_ch.ready <= (tick % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    box_t got;
    box_t want;
    int   ax;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.lo = {out_ch.out_min_z, out_ch.out_min_y, out_ch.out_min_x};
      got.hi = {out_ch.out_max_z, out_ch.out_max_y, out_ch.out_max_x};
      if (box_expect_q.size() == 0) begin
        report_error("Result transaction arrived with no transform pending.");
      end else begin
        want = box_expect_q.pop_front();
        for (ax = 0; ax < amt_pkg::NUM_AXES; ax++) begin
          if (got.lo[ax] !== want.lo[ax]) begin
            report_error($sformatf("min axis %0d: got %h, expected %h",
                                   ax, got.lo[ax], want.lo[ax]));
          end
          if (got.hi[ax] !== want.hi[ax]) begin
            report_error($sformatf("max axis %0d: got %h, expected %h",
                                   ax, got.hi[ax], want.hi[ax]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

FILE: sim.f
design/amt_pkg.sv
design/amt_if.sv
design/amt_axis.sv
design/aabb_matrix_transform.sv
test/testbench.sv
